[design/mcsr_pkg.sv]
// Package for the memory card serial responder: phase codes, constants and
// the stage-one result descriptor. No dependencies.
package mcsr_pkg;

  localparam int CARD_BYTES = 131072;          // power of two, 16384 .. 131072
  localparam int CARD_AW    = $clog2(CARD_BYTES);
  localparam int PTR_W      = 17;
  localparam int FRAME_W    = 10;

  localparam logic [4:0] PH_IDLE   = 5'd0;
  localparam logic [4:0] PH_FLAG   = 5'd1;
  localparam logic [4:0] PH_ID1    = 5'd2;
  localparam logic [4:0] PH_ID2    = 5'd3;
  localparam logic [4:0] PH_R_MSB  = 5'd4;
  localparam logic [4:0] PH_R_LSB  = 5'd5;
  localparam logic [4:0] PH_R_ACK1 = 5'd6;
  localparam logic [4:0] PH_R_ACK2 = 5'd7;
  localparam logic [4:0] PH_R_TMSB = 5'd8;
  localparam logic [4:0] PH_R_TLSB = 5'd9;
  localparam logic [4:0] PH_R_DATA = 5'd10;
  localparam logic [4:0] PH_R_CHK  = 5'd11;
  localparam logic [4:0] PH_R_END  = 5'd12;
  localparam logic [4:0] PH_W_MSB  = 5'd13;
  localparam logic [4:0] PH_W_LSB  = 5'd14;
  localparam logic [4:0] PH_W_DATA = 5'd15;
  localparam logic [4:0] PH_W_CHK  = 5'd16;
  localparam logic [4:0] PH_W_ACK1 = 5'd17;
  localparam logic [4:0] PH_W_ACK2 = 5'd18;
  localparam logic [4:0] PH_W_END  = 5'd19;
  localparam logic [4:0] PH_S_ACK1 = 5'd20;
  localparam logic [4:0] PH_S_ACK2 = 5'd21;
  localparam logic [4:0] PH_S_D0   = 5'd22;
  localparam logic [4:0] PH_S_D1   = 5'd23;
  localparam logic [4:0] PH_S_D2   = 5'd24;
  localparam logic [4:0] PH_S_D3   = 5'd25;

  localparam logic [7:0] CMD_READ  = 8'h52;  // 'R'
  localparam logic [7:0] CMD_WRITE = 8'h57;  // 'W'
  localparam logic [7:0] CMD_ID    = 8'h53;  // 'S'

  localparam logic [7:0] BYTE_IDLE = 8'hff;
  localparam logic [7:0] BYTE_ID1  = 8'h5a;
  localparam logic [7:0] BYTE_ID2  = 8'h5d;
  localparam logic [7:0] BYTE_ACK1 = 8'h5c;
  localparam logic [7:0] BYTE_END  = 8'h47;  // 'G'
  localparam logic [7:0] BYTE_SD0  = 8'h04;
  localparam logic [7:0] BYTE_SD3  = 8'h80;
  localparam logic [7:0] FLAG_RST  = 8'h08;
  localparam logic [7:0] FLAG_WMASK = 8'hf7;
  localparam logic [7:0] FRAME_BYTES = 8'd128;

  typedef enum logic [1:0] {ADV_END, ADV_NEXT, ADV_STAY} adv_t;
  typedef enum logic [1:0] {SEL_CONST, SEL_MEM, SEL_CHK} reply_sel_t;
  typedef enum logic [1:0] {CHK_NONE, CHK_LOAD, CHK_XOR} chk_op_t;

  typedef struct packed {
    logic [7:0]         reply;
    reply_sel_t         sel;
    chk_op_t            chk_op;
    logic               ack;
    logic               marked;
    logic [FRAME_W-1:0] frame;
  } stage_t;

endpackage

[design/memory_card_serial_responder.sv]
// Top level of the memory card serial responder: protocol sequencer, card
// byte memory and output register. Depends on mcsr_pkg.
//
// Usage: each transfer on the in_ channel is one exchange. in_tuser = 0
// exchanges in_tdata (host byte); in_tuser = 1 deselects the port and
// returns the card to idle. Every input transfer yields exactly one
// out_ transfer carrying the card reply, acknowledge and, on the second
// address exchange of a write command, the frame that was addressed.
// Throughput: one exchange per cycle while the output is not stalled. The
// sequencer steps at the input transfer; the card memory read issued
// there comes back in the next cycle and is merged into the result in
// stage one, and the result then passes through the output register to
// out_tvalid and out_tdata. The read checksum is accumulated as results
// leave stage one.
// Reset (rst_n low, synchronous) empties both stages and puts the
// sequencer in idle with the status flag at 0x08; the card memory keeps
// its contents and is not cleared. When the receiver holds out_tready
// low the output holds, stage one fills, and then in_tready drops.
module memory_card_serial_responder (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] host_byte
  input  logic        in_tuser,   // [0] kind
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [23:0] out_tdata   // [7:0] reply_byte, [8] acknowledge,
                                  // [9] frame_marked, [19:10] marked_frame
);
  import mcsr_pkg::*;

  logic [4:0]       phase_r, phase_nxt;
  logic [7:0]       cmd_r, cmd_nxt;
  logic [7:0]       addr_hi_r, addr_hi_nxt;
  logic [7:0]       addr_lo_r, addr_lo_nxt;
  logic [PTR_W-1:0] ptr_r, ptr_nxt;
  logic [7:0]       left_r, left_nxt;
  logic [7:0]       chk_r, chk_nxt;
  logic [7:0]       recv_r, recv_nxt;
  logic [7:0]       flag_r, flag_nxt;
  logic             ack_r, ack_nxt;

  logic             s1_v_r, s1_v_nxt;
  stage_t           s1_r, s1_nxt;
  logic             out_v_r, out_v_nxt;
  logic [23:0]      out_r, out_nxt;

  logic [7:0]       mem [CARD_BYTES];
  logic [7:0]       mem_rd_r;
  logic             mem_rd_en, mem_wr_en;

  logic             accept, s1_move;
  adv_t             adv;
  logic [FRAME_W-1:0] frame_in;
  logic [7:0]       left_dec;
  logic [7:0]       s1_reply;

  assign s1_move   = !out_v_r || out_tready;
  assign in_tready = !s1_v_r || s1_move;
  assign accept    = in_tvalid && in_tready;

  assign frame_in  = {addr_hi_r[1:0], in_tdata};
  assign left_dec  = left_r - 8'd1;

  // sequencer step for the accepted exchange
  always_comb begin
    phase_nxt   = phase_r;
    cmd_nxt     = cmd_r;
    addr_hi_nxt = addr_hi_r;
    addr_lo_nxt = addr_lo_r;
    ptr_nxt     = ptr_r;
    left_nxt    = left_r;
    recv_nxt    = recv_r;
    flag_nxt    = flag_r;
    ack_nxt     = ack_r;
    adv         = ADV_NEXT;
    mem_rd_en   = 1'b0;
    mem_wr_en   = 1'b0;
    s1_nxt.reply  = BYTE_IDLE;
    s1_nxt.sel    = SEL_CONST;
    s1_nxt.chk_op = CHK_NONE;
    s1_nxt.ack    = 1'b0;
    s1_nxt.marked = 1'b0;
    s1_nxt.frame  = '0;

    if (in_tuser) begin
      phase_nxt = PH_IDLE;
      ack_nxt   = 1'b0;
      adv       = ADV_STAY;
    end else begin
      unique case (phase_r)
        PH_IDLE: s1_nxt.reply = BYTE_IDLE;
        PH_FLAG: begin
          cmd_nxt      = in_tdata;
          s1_nxt.reply = flag_r;
          if (in_tdata != CMD_READ && in_tdata != CMD_WRITE && in_tdata != CMD_ID)
            adv = ADV_END;
        end
        PH_ID1: s1_nxt.reply = BYTE_ID1;
        PH_ID2: begin
          s1_nxt.reply = BYTE_ID2;
          adv          = ADV_STAY;
          ack_nxt      = 1'b1;
          priority if (cmd_r == CMD_READ) phase_nxt = PH_R_MSB;
          else if (cmd_r == CMD_WRITE)    phase_nxt = PH_W_MSB;
          else if (cmd_r == CMD_ID)       phase_nxt = PH_S_ACK1;
          else begin
            ack_nxt   = 1'b0;
            phase_nxt = PH_IDLE;
          end
        end
        PH_R_MSB, PH_W_MSB: begin
          addr_hi_nxt  = in_tdata;
          s1_nxt.reply = 8'h00;
        end
        PH_R_LSB: begin
          addr_lo_nxt  = in_tdata;
          ptr_nxt      = {frame_in, 7'd0};
          s1_nxt.reply = addr_hi_r;
        end
        PH_W_LSB: begin
          addr_lo_nxt   = in_tdata;
          ptr_nxt       = {frame_in, 7'd0};
          left_nxt      = FRAME_BYTES;
          s1_nxt.reply  = addr_hi_r;
          s1_nxt.marked = 1'b1;
          s1_nxt.frame  = frame_in;
        end
        PH_R_ACK1, PH_W_ACK1, PH_S_ACK1: s1_nxt.reply = BYTE_ACK1;
        PH_R_ACK2, PH_W_ACK2, PH_S_ACK2: s1_nxt.reply = BYTE_ID2;
        PH_R_TMSB: begin
          s1_nxt.reply  = addr_hi_r;
          s1_nxt.chk_op = CHK_LOAD;
        end
        PH_R_TLSB: begin
          s1_nxt.reply  = addr_lo_r;
          s1_nxt.chk_op = CHK_XOR;
          left_nxt      = FRAME_BYTES;
        end
        PH_R_DATA: begin
          left_nxt      = left_dec;
          mem_rd_en     = 1'b1;
          ptr_nxt       = ptr_r + 1'b1;
          s1_nxt.sel    = SEL_MEM;
          s1_nxt.chk_op = CHK_XOR;
          if (left_dec != 8'd0) adv = ADV_STAY;
        end
        PH_R_CHK: s1_nxt.sel = SEL_CHK;
        PH_R_END: begin
          s1_nxt.reply = BYTE_END;
          adv          = ADV_END;
        end
        PH_W_DATA: begin
          left_nxt     = left_dec;
          recv_nxt     = in_tdata;
          mem_wr_en    = 1'b1;
          ptr_nxt      = ptr_r + 1'b1;
          s1_nxt.reply = in_tdata;
          if (left_dec != 8'd0) adv = ADV_STAY;
        end
        PH_W_CHK: s1_nxt.reply = recv_r;
        PH_W_END: begin
          s1_nxt.reply = BYTE_END;
          flag_nxt     = flag_r & FLAG_WMASK;
          adv          = ADV_END;
        end
        PH_S_D0: s1_nxt.reply = BYTE_SD0;
        PH_S_D1, PH_S_D2: s1_nxt.reply = 8'h00;
        PH_S_D3: begin
          s1_nxt.reply = BYTE_SD3;
          adv          = ADV_END;
        end
        default: begin
          s1_nxt.reply = BYTE_IDLE;
          adv          = ADV_END;
        end
      endcase

      unique case (adv)
        ADV_NEXT: begin
          ack_nxt   = 1'b1;
          phase_nxt = phase_r + 5'd1;
        end
        ADV_END: begin
          ack_nxt   = 1'b0;
          phase_nxt = PH_IDLE;
        end
        default: ;
      endcase
    end
    s1_nxt.ack = ack_nxt;
  end

  // stage one resolve: memory data and checksum merge, in result order
  always_comb begin
    unique case (s1_r.sel)
      SEL_MEM: s1_reply = mem_rd_r;
      SEL_CHK: s1_reply = chk_r;
      default: s1_reply = s1_r.reply;
    endcase
    chk_nxt = chk_r;
    if (s1_v_r && s1_move) begin
      unique case (s1_r.chk_op)
        CHK_LOAD: chk_nxt = s1_reply;
        CHK_XOR:  chk_nxt = chk_r ^ s1_reply;
        default:  chk_nxt = chk_r;
      endcase
    end
    out_nxt   = {4'd0, s1_r.frame, s1_r.marked, s1_r.ack, s1_reply};
    s1_v_nxt  = accept ? 1'b1 : (s1_move ? 1'b0 : s1_v_r);
    out_v_nxt = s1_move ? s1_v_r : out_v_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r   <= PH_IDLE;
      cmd_r     <= '0;
      addr_hi_r <= '0;
      addr_lo_r <= '0;
      ptr_r     <= '0;
      left_r    <= '0;
      chk_r     <= '0;
      recv_r    <= '0;
      flag_r    <= FLAG_RST;
      ack_r     <= 1'b0;
      s1_v_r    <= 1'b0;
      out_v_r   <= 1'b0;
    end else begin
      if (accept) begin
        phase_r   <= phase_nxt;
        cmd_r     <= cmd_nxt;
        addr_hi_r <= addr_hi_nxt;
        addr_lo_r <= addr_lo_nxt;
        ptr_r     <= ptr_nxt;
        left_r    <= left_nxt;
        recv_r    <= recv_nxt;
        flag_r    <= flag_nxt;
        ack_r     <= ack_nxt;
      end
      chk_r   <= chk_nxt;
      s1_v_r  <= s1_v_nxt;
      out_v_r <= out_v_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (accept) s1_r <= s1_nxt;
    if (s1_move && s1_v_r) out_r <= out_nxt;
  end

  // card memory: one port, read or write per exchange
  always_ff @(posedge clk) begin
    if (accept && mem_wr_en) mem[ptr_r[CARD_AW-1:0]] <= in_tdata;
    if (accept && mem_rd_en) mem_rd_r <= mem[ptr_r[CARD_AW-1:0]];
  end

  assign out_tvalid = out_v_r;
  assign out_tdata  = out_r;

endmodule

[design/mcsr_checker.sv]
// Port-level checks for the memory card serial responder, bound to the top
// level. Depends on memory_card_serial_responder.
module mcsr_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [23:0] out_tdata
);

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result changed while stalled");

  // a write frame is reported only mid-sequence, so it always carries ack
  a_mark_ack: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[9] |-> out_tdata[8])
    else $error("frame marked without acknowledge");

  a_frame_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tdata[9] |-> out_tdata[19:10] == 10'd0)
    else $error("frame number set without mark");

  a_pad_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[23:20] == 4'd0)
    else $error("padding bits set");

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result valid after reset");

endmodule

bind memory_card_serial_responder mcsr_checker u_mcsr_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);
